>>> design/rdsm_pkg.sv
// rdsm_pkg: shared types and constants for the dot-star pattern matcher.
// No dependencies; imported by every module of the block.
package rdsm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_FINISH  = 2'd3
    } cmd_t;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] char_code;
    } req_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } res_t;

    // column-wide strobes broadcast to every cell
    typedef struct packed {
        logic clear;
        logic subject;
        logic rearm;
    } col_ctrl_t;

endpackage

>>> design/regex_dot_star_matcher.sv
// regex_dot_star_matcher: anchored matcher for patterns with '.' and 'x*'.
// Depends on rdsm_pkg, rdsm_cell and rdsm_outbuf.
//
// Usage: one request channel (in_valid/in_ready/in_data) carries commands:
// clear pattern, append pattern byte, subject byte, finish subject. Only a
// finish produces a reply on out_valid/out_ready/out_data: the match flag for
// the whole subject and the sticky pattern overflow flag.
// The chain of PATTERN_MAX cells updates the whole match column for each accepted
// request, so one request per clock is sustained while in_ready stays high. The
// longest path is the star-to-star ripple through the cells of one column step.
// A finish reply is registered in the output register, or in skid while stalled.
// Replies wait in a two-entry buffer; while the receiver stalls, requests keep
// flowing until a second reply is waiting, then in_ready drops until the
// receiver takes one.
// Reset clears the pattern length, the overflow flag and both columns (only the
// empty-prefix bit set) and empties the reply buffer. Pattern bytes past
// PATTERN_MAX are dropped and set the overflow flag until the next clear.
module regex_dot_star_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rdsm_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rdsm_pkg::res_t out_data
);
    import rdsm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic                 in_go;
    logic                 full;
    logic                 append_go;
    col_ctrl_t            ctrl;
    logic [LEN_W-1:0]     length_reg;
    logic [LEN_W-1:0]     length_next;
    logic                 overflow_reg;
    logic                 overflow_next;
    logic                 m0_reg;
    logic                 m0_next;
    logic [PATTERN_MAX:0] m_col;
    logic [PATTERN_MAX:0] e_col;
    logic [PATTERN_MAX:0] step_col;
    logic [7:0]           char_col [1:PATTERN_MAX];
    res_t                 reply;
    logic                 push;

    assign in_go     = in_valid && in_ready;
    assign full      = (length_reg == LEN_W'(PATTERN_MAX));
    assign append_go = in_go && (in_data.command == CMD_APPEND) && !full;

    assign ctrl.clear   = in_go && (in_data.command == CMD_CLEAR);
    assign ctrl.subject = in_go && (in_data.command == CMD_SUBJECT);
    assign ctrl.rearm   = append_go || (in_go && (in_data.command == CMD_FINISH));

    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        m0_next       = m0_reg;
        if (ctrl.clear)
        begin
            length_next   = '0;
            overflow_next = 1'b0;
            m0_next       = 1'b1;
        end
        else if (ctrl.subject)
            m0_next = 1'b0;
        else if (ctrl.rearm)
            m0_next = 1'b1;
        if (append_go)
            length_next = length_reg + LEN_W'(1);
        else if (in_go && (in_data.command == CMD_APPEND))
            overflow_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            overflow_reg <= 1'b0;
            m0_reg       <= 1'b1;
        end
        else
        begin
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
            m0_reg       <= m0_next;
        end
    end

    // position zero: the empty pattern prefix
    assign m_col[0]    = m0_reg;
    assign e_col[0]    = 1'b1;
    assign step_col[0] = 1'b0;

    for (genvar i = 1; i <= PATTERN_MAX; i++)
    begin : g_cell
        logic [7:0] prev_char;
        logic       e_left2;
        logic       step_left2;

        if (i >= 2)
        begin : g_left
            assign prev_char  = char_col[i-1];
            assign e_left2    = e_col[i-2];
            assign step_left2 = step_col[i-2];
        end
        else
        begin : g_first
            assign prev_char  = 8'h00;
            assign e_left2    = 1'b0;
            assign step_left2 = 1'b0;
        end

        rdsm_cell #(
            .HAS_PREV (i >= 2)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .write_en   (append_go && (length_reg == LEN_W'(i - 1))),
            .active     (LEN_W'(i) <= length_reg),
            .ch         (in_data.char_code),
            .prev_char  (prev_char),
            .m_left     (m_col[i-1]),
            .e_left2    (e_left2),
            .step_left2 (step_left2),
            .pat_char   (char_col[i]),
            .e_bit      (e_col[i]),
            .m_bit      (m_col[i]),
            .step_bit   (step_col[i])
        );
    end

    assign reply.matched          = m_col[length_reg];
    assign reply.pattern_overflow = overflow_reg;
    assign push                   = in_go && (in_data.command == CMD_FINISH);

    rdsm_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (reply),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> design/rdsm_cell.sv
// rdsm_cell: one pattern position; holds its byte plus empty/match column bits.
// Depends on rdsm_pkg; chained by the top level, each cell reading its left neighbours.
module rdsm_cell #(
    parameter bit HAS_PREV = 1'b1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rdsm_pkg::col_ctrl_t ctrl,
    input  logic                write_en,
    input  logic                active,
    input  logic [7:0]          ch,
    input  logic [7:0]          prev_char,
    input  logic                m_left,
    input  logic                e_left2,
    input  logic                step_left2,
    output logic [7:0]          pat_char,
    output logic                e_bit,
    output logic                m_bit,
    output logic                step_bit
);
    import rdsm_pkg::*;

    logic [7:0] char_reg;
    logic       e_reg;
    logic       e_next;
    logic       m_reg;
    logic       m_next;
    logic       is_star;
    logic       acc_self;
    logic       acc_prev;

    assign is_star  = (char_reg == CH_STAR);
    assign acc_self = (char_reg == CH_DOT) || (char_reg == ch);
    assign acc_prev = (prev_char == CH_DOT) || (prev_char == ch);

    // a star with nothing before it never matches; a star repeats only its left item
    always_comb
    begin
        if (!active)
            step_bit = 1'b0;
        else if (is_star)
            step_bit = HAS_PREV ? (step_left2 | (acc_prev & m_reg)) : 1'b0;
        else
            step_bit = acc_self & m_left;
    end

    always_comb
    begin
        e_next = e_reg;
        if (ctrl.clear)
            e_next = 1'b0;
        else if (write_en)
            e_next = (ch == CH_STAR && HAS_PREV) ? e_left2 : 1'b0;
    end

    always_comb
    begin
        m_next = m_reg;
        if (ctrl.clear)
            m_next = 1'b0;
        else if (ctrl.subject)
            m_next = step_bit;
        else if (ctrl.rearm)
            m_next = e_next;
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
            char_reg <= ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= 1'b0;
            m_reg <= 1'b0;
        end
        else
        begin
            e_reg <= e_next;
            m_reg <= m_next;
        end
    end

    assign pat_char = char_reg;
    assign e_bit    = e_reg;
    assign m_bit    = m_reg;

endmodule

>>> design/rdsm_outbuf.sv
// rdsm_outbuf: two-entry result buffer (output register plus skid) for finish replies.
// Depends on rdsm_pkg for the result struct.
module rdsm_outbuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rdsm_pkg::res_t push_data,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output rdsm_pkg::res_t out_data
);
    import rdsm_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_data_reg;
    res_t out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_data_reg;
    res_t skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                // push cannot coincide here: room is low while skid is full
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/rdsm_checker.sv
// rdsm_checker: port-level checks on the matcher's request and reply channels.
// Depends on rdsm_pkg; bound to regex_dot_star_matcher below.
module rdsm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input rdsm_pkg::req_t in_data,
    input logic           out_valid,
    input logic           out_ready,
    input rdsm_pkg::res_t out_data
);
    import rdsm_pkg::*;

    // a stalled reply holds
    a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("reply changed while stalled");

    // every accepted finish leaves a reply pending next cycle
    a_finish_reply: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command == CMD_FINISH |=> out_valid)
        else $error("finish request produced no reply");

    // other commands never create a reply from an empty buffer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && in_ready && in_data.command == CMD_FINISH)
        |=> !out_valid)
        else $error("reply without a finish request");

    // back-pressure only when replies are actually waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request side stalled with no reply pending");

endmodule

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> sim/rdsm_reply_checker.sv
// rdsm_reply_checker: watches both channels of the dot-star matcher, keeps its own
// copy of the pattern and match columns, and compares every reply in order.
// Depends on rdsm_pkg; instantiated beside the block by tb_regex_dot_star_matcher.
`timescale 1ns / 100ps

module rdsm_reply_checker #(
    parameter int PATTERN_MAX = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  rdsm_pkg::req_t in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  rdsm_pkg::res_t out_data,
    output int             fail_count,
    output int             replies_due
);
    import rdsm_pkg::*;

    logic [7:0]           pat_mem [PATTERN_MAX];
    int unsigned          pat_len;
    logic [PATTERN_MAX:0] empty_col;
    logic [PATTERN_MAX:0] match_col;
    logic                 overflow_seen;
    res_t                 verdicts_due [$];

    function automatic logic byte_fits(input logic [7:0] item, input logic [7:0] c);
        return (item == CH_DOT) || (item == c);
    endfunction

    task automatic wipe_pattern();
        pat_len       = 0;
        empty_col     = '0;
        empty_col[0]  = 1'b1;
        overflow_seen = 1'b0;
        match_col     = empty_col;
    endtask

    task automatic add_pattern_byte(input logic [7:0] c);
        if (pat_len >= PATTERN_MAX)
        begin
            overflow_seen = 1'b1;
        end
        else
        begin
            pat_mem[pat_len] = c;
            pat_len++;
            // a star only repeats something when it has a predecessor
            if (c == CH_STAR && pat_len >= 2)
                empty_col[pat_len] = empty_col[pat_len - 2];
            else
                empty_col[pat_len] = 1'b0;
            match_col = empty_col;
        end
    endtask

    task automatic advance_column(input logic [7:0] c);
        logic [PATTERN_MAX:0] nxt;
        int                   i;
        nxt = '0;
        for (i = 1; i <= pat_len; i++)
        begin
            if (pat_mem[i - 1] == CH_STAR)
            begin
                if (i < 2)
                    nxt[i] = 1'b0;
                else if (byte_fits(pat_mem[i - 2], c))
                    nxt[i] = nxt[i - 2] | match_col[i];
                else
                    nxt[i] = nxt[i - 2];
            end
            else
            begin
                nxt[i] = byte_fits(pat_mem[i - 1], c) ? match_col[i - 1] : 1'b0;
            end
        end
        match_col = nxt;
    endtask

    task automatic predict_request(input req_t rq);
        res_t verdict;
        case (rq.command)
            CMD_CLEAR:   wipe_pattern();
            CMD_APPEND:  add_pattern_byte(rq.char_code);
            CMD_SUBJECT: advance_column(rq.char_code);
            CMD_FINISH:
            begin
                verdict.matched          = match_col[pat_len];
                verdict.pattern_overflow = overflow_seen;
                verdicts_due = {verdicts_due, verdict};
                match_col = empty_col;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            foreach (pat_mem[k]) pat_mem[k] = 8'h00;
            wipe_pattern();
            verdicts_due.delete();
            fail_count  <= 0;
            replies_due <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_request(in_data);
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("reply with no request outstanding: matched=%0b overflow=%0b",
                           out_data.matched, out_data.pattern_overflow);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (out_data.matched !== want.matched)
                    begin
                        $error("matched: expected %0b, got %0b",
                               want.matched, out_data.matched);
                        fail_count <= fail_count + 1;
                    end
                    else if (out_data.pattern_overflow !== want.pattern_overflow)
                    begin
                        $error("pattern_overflow: expected %0b, got %0b",
                               want.pattern_overflow, out_data.pattern_overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            replies_due <= verdicts_due.size();
        end
    end

endmodule

>>> sim/tb_regex_dot_star_matcher.sv
// tb_regex_dot_star_matcher: drives directed and random request streams into the
// dot-star matcher, with random idling on both sides and one long receiver stall.
// Depends on rdsm_pkg, regex_dot_star_matcher and rdsm_reply_checker.
`timescale 1ns / 100ps

module tb_regex_dot_star_matcher;
    import rdsm_pkg::*;

    localparam int PATTERN_MAX  = 32;
    localparam int RANDOM_REQS  = 1500;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_LEN     = 300;
    localparam int RX_CALM_FROM = 1400;
    localparam int RX_CALM_TO   = 1800;
    localparam logic [7:0] CH_A = "a";
    localparam logic [7:0] CH_B = "b";
    localparam logic [7:0] CH_C = "c";

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    req_t in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    res_t out_data;

    int   fail_count;
    int   replies_due;
    int   cycle_count = 0;
    int   reqs_sent   = 0;
    bit   steady_tx   = 1'b0;

    always #2 clk = ~clk;

    regex_dot_star_matcher #(.PATTERN_MAX(PATTERN_MAX)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    rdsm_reply_checker #(.PATTERN_MAX(PATTERN_MAX)) u_reply_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .replies_due(replies_due)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, one calm window
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (cycle_count == HOLD_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            if (cycle_count >= RX_CALM_FROM && cycle_count < RX_CALM_TO)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 29);
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic push_req(input cmd_t cmd, input logic [7:0] ch);
        if (!steady_tx)
        begin
            while ($urandom_range(99) < 29)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid          <= 1'b1;
        in_data.command   <= cmd;
        in_data.char_code <= ch;
        do @(posedge clk); while (!in_ready);
        reqs_sent++;
    endtask

    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(9))
            0, 1, 2: return CH_A;
            3, 4:    return CH_B;
            5:       return CH_DOT;
            6, 7:    return CH_STAR;
            8:       return CH_C;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_stray_byte();
        case ($urandom_range(3))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_STAR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one subject shaped after the pattern so that matches are common
    task automatic send_subject(input logic [7:0] pat [40], input int plen);
        int         j;
        int         reps;
        int         use_len;
        logic [7:0] item;
        use_len = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
        j = 0;
        while (j < use_len)
        begin
            item = pat[j];
            if (item != CH_STAR && j + 1 < use_len && pat[j + 1] == CH_STAR)
            begin
                reps = $urandom_range(3);
                repeat (reps)
                    push_req(CMD_SUBJECT, (item == CH_DOT) ? 8'($urandom_range(255)) : item);
                j += 2;
            end
            else
            begin
                push_req(CMD_SUBJECT, (item == CH_DOT) ? 8'($urandom_range(255)) : item);
                j++;
            end
        end
        if ($urandom_range(4) == 0)
            push_req(CMD_SUBJECT, pick_stray_byte());
        push_req(CMD_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic run_session();
        logic [7:0] pat [40];
        int         plen;
        int         n;
        plen = ($urandom_range(14) == 0) ? $urandom_range(30, 35) : $urandom_range(7);
        push_req(CMD_CLEAR, 8'($urandom_range(255)));
        for (n = 0; n < plen; n++)
        begin
            pat[n] = pick_pattern_byte();
            push_req(CMD_APPEND, pat[n]);
        end
        for (n = $urandom_range(1, 4); n > 0; n--)
            send_subject(pat, plen);
    endtask

    task automatic send_noise();
        int n;
        for (n = $urandom_range(1, 6); n > 0; n--)
            push_req(cmd_t'($urandom_range(3)), pick_stray_byte());
    endtask

    initial
    begin
        int random_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern against empty subject, then against one byte
        push_req(CMD_FINISH, 8'h00);
        push_req(CMD_SUBJECT, 8'hFF);
        push_req(CMD_FINISH, 8'hFF);
        // leading star never matches
        push_req(CMD_APPEND, CH_STAR);
        push_req(CMD_FINISH, 8'h00);
        push_req(CMD_SUBJECT, 8'h00);
        push_req(CMD_FINISH, 8'h00);
        push_req(CMD_CLEAR, 8'hFF);
        // appends part-way through a subject restart it; second star is literal
        push_req(CMD_APPEND, CH_A);
        push_req(CMD_SUBJECT, CH_A);
        push_req(CMD_APPEND, CH_STAR);
        push_req(CMD_APPEND, CH_STAR);
        push_req(CMD_SUBJECT, CH_A);
        push_req(CMD_SUBJECT, CH_STAR);
        push_req(CMD_FINISH, 8'h00);
        // dot-star swallows anything, including nothing
        push_req(CMD_CLEAR, 8'h00);
        push_req(CMD_APPEND, CH_DOT);
        push_req(CMD_APPEND, CH_STAR);
        push_req(CMD_SUBJECT, 8'h80);
        push_req(CMD_SUBJECT, 8'h7F);
        push_req(CMD_FINISH, 8'h00);
        push_req(CMD_FINISH, 8'h00);

        random_start = reqs_sent;
        while (reqs_sent - random_start < RANDOM_REQS)
        begin
            steady_tx = (reqs_sent - random_start >= 700) && (reqs_sent - random_start < 1000);
            if ($urandom_range(99) < 75)
                run_session();
            else
                send_noise();
        end
        in_valid <= 1'b0;

        // let the checker count the last accepted request first
        @(posedge clk);
        while (replies_due != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
